[rtl/tud_pkg.sv]
package tud_pkg;

  // Number of terminal units and the index width that follows from it.
  localparam int unsigned NUM_UNITS = 4;
  localparam int unsigned UNIT_W    = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;

  // Function codes of an input word.
  localparam logic [1:0] FN_READ  = 2'd0;
  localparam logic [1:0] FN_WRITE = 2'd1;
  localparam logic [1:0] FN_TICK  = 2'd2;

  // Result codes.
  localparam logic [1:0] RC_OK      = 2'd0;
  localparam logic [1:0] RC_BUSY    = 2'd1;
  localparam logic [1:0] RC_INVALID = 2'd2;

  // Status word layout.
  localparam logic [15:0] ST_RECV_MASK = 16'h0003;
  localparam logic [15:0] ST_XMIT_MASK = 16'h000c;
  localparam logic [15:0] ST_RECV_BUSY = 16'h0001;
  localparam logic [15:0] ST_XMIT_BUSY = 16'h0004;
  localparam logic [1:0]  XS_READY     = 2'd0;
  localparam logic [1:0]  XS_BUSY      = 2'd1;

  // Control word bits.
  localparam int unsigned CTL_SEND_BIT   = 0;
  localparam int unsigned CTL_RX_IRQ_BIT = 1;
  localparam int unsigned CTL_TX_IRQ_BIT = 2;

  // A received pause character is not latched.
  localparam logic [7:0] PAUSE_CHAR = 8'h40;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  unit;
    logic [15:0] control_word;
    logic        rx_present;
    logic [7:0]  rx_char;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  result_code;
    logic [15:0] status_word;
    logic        tx_valid;
    logic [7:0]  tx_char;
    logic [1:0]  tx_unit;
    logic [1:0]  polled_unit;
    logic        irq_valid;
    logic [1:0]  irq_unit;
  } out_word_t;

  // Write-back request from the update logic to the memories.
  typedef struct packed {
    logic        st_we;
    logic [15:0] st_wdata;
    logic        ct_we;
    logic [15:0] ct_wdata;
  } upd_t;

endpackage

[rtl/tud_if.sv]
// Input channel.
interface tud_in_if;
  import tud_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Output channel.
interface tud_out_if;
  import tud_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/tud_ram.sv]
module tud_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/tud_update.sv]
module tud_update
  import tud_pkg::*;
(
  input  in_word_t          req_i,
  input  logic [UNIT_W-1:0] addr_i,
  input  logic [15:0]       st_i,
  input  logic [15:0]       ct_i,
  output upd_t              upd_o,
  output out_word_t         res_o
);

  // Modify step: work out the new status and control words and the result.
  always_comb begin
    logic        unit_ok;
    logic [15:0] st;
    logic        irq;
    unit_ok = (32'(req_i.unit) < 32'(NUM_UNITS));
    st      = st_i;
    irq     = 1'b0;
    upd_o   = '0;
    res_o   = '0;
    case (req_i.func)
      FN_READ: begin
        if (!unit_ok) begin
          res_o.result_code = RC_INVALID;
        end else begin
          res_o.status_word = st_i;
          upd_o.st_we       = 1'b1;
          upd_o.st_wdata    = st_i & ~ST_RECV_MASK;
        end
      end
      FN_WRITE: begin
        if (!unit_ok) begin
          res_o.result_code = RC_INVALID;
        end else begin
          upd_o.ct_we    = 1'b1;
          upd_o.ct_wdata = req_i.control_word;
          if (req_i.control_word[CTL_SEND_BIT]) begin
            if (st_i[3:2] == XS_READY) begin
              res_o.tx_valid = 1'b1;
              res_o.tx_char  = req_i.control_word[15:8];
              res_o.tx_unit  = req_i.unit[1:0];
              upd_o.st_we    = 1'b1;
              upd_o.st_wdata = (st_i & ~ST_XMIT_MASK) | ST_XMIT_BUSY;
            end else if (st_i[3:2] == XS_BUSY) begin
              res_o.result_code = RC_BUSY;
            end
          end
        end
      end
      FN_TICK: begin
        // Latch a real character, otherwise drop receive back to ready.
        if (req_i.rx_present && (req_i.rx_char != PAUSE_CHAR)) begin
          st  = {req_i.rx_char, st[7:0]};
          st  = (st & ~ST_RECV_MASK) | ST_RECV_BUSY;
          irq = ct_i[CTL_RX_IRQ_BIT];
        end else begin
          st = st & ~ST_RECV_MASK;
        end
        // Retire a pending transmit.
        if (st[3:2] == XS_BUSY) begin
          st  = st & ~ST_XMIT_MASK;
          irq = irq | ct_i[CTL_TX_IRQ_BIT];
        end
        upd_o.st_we       = 1'b1;
        upd_o.st_wdata    = st;
        res_o.polled_unit = 2'(addr_i);
        res_o.irq_valid   = irq;
        res_o.irq_unit    = irq ? 2'(addr_i) : 2'd0;
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

[rtl/four_unit_terminal_device.sv]
// Terminal block with NUM_UNITS units, each holding a control word and a status
// word in two small memories. A word on the input channel is a status read, a
// control write or a poll tick; each gives exactly one result word. A word is
// accepted in S_IDLE, which reads both memories; S_EXEC then modifies the
// entries, writes them back and loads the result register, so the block
// takes a new word only after the last has left S_EXEC, as long as results are taken.
// This order is set by the registered read of the memories ahead of the write-back.
// Per-entry valid bits make every unit read as zero after reset, so no
// clearing pass is needed and the block is ready right after reset.
module four_unit_terminal_device
  import tud_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  tud_in_if.sink    in_i,
  tud_out_if.source out_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e            state_q;
  logic              out_vld_q;
  out_word_t         out_data_q;
  in_word_t          req_q;
  logic [UNIT_W-1:0] addr_q;
  logic [UNIT_W-1:0] ptr_q;
  logic [NUM_UNITS-1:0] st_vld_q;
  logic [NUM_UNITS-1:0] ct_vld_q;

  logic              accept;
  logic [UNIT_W-1:0] ptr_d;
  logic [UNIT_W-1:0] raddr;
  logic [15:0]       st_rdata;
  logic [15:0]       ct_rdata;
  logic [15:0]       st_eff;
  logic [15:0]       ct_eff;
  upd_t              upd;
  out_word_t         res;

  // Take a word while idle and the result slot is free or draining.
  assign in_i.ready = (state_q == S_IDLE) && (!out_vld_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  // Round-robin poll pointer.
  assign ptr_d = (32'(ptr_q) == NUM_UNITS - 1) ? '0 : ptr_q + 1'b1;
  assign raddr = (in_i.data.func == FN_TICK) ? ptr_d : UNIT_W'(in_i.data.unit);

  // Entries never written read as their reset value of zero.
  assign st_eff = st_vld_q[addr_q] ? st_rdata : 16'h0000;
  assign ct_eff = ct_vld_q[addr_q] ? ct_rdata : 16'h0000;

  tud_ram #(.WIDTH(16), .DEPTH(NUM_UNITS)) u_status_ram (
    .clk_i   (clk_i),
    .we_i    (upd.st_we && (state_q == S_EXEC)),
    .waddr_i (addr_q),
    .wdata_i (upd.st_wdata),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (st_rdata)
  );

  tud_ram #(.WIDTH(16), .DEPTH(NUM_UNITS)) u_control_ram (
    .clk_i   (clk_i),
    .we_i    (upd.ct_we && (state_q == S_EXEC)),
    .waddr_i (addr_q),
    .wdata_i (upd.ct_wdata),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (ct_rdata)
  );

  tud_update u_update (
    .req_i  (req_q),
    .addr_i (addr_q),
    .st_i   (st_eff),
    .ct_i   (ct_eff),
    .upd_o  (upd),
    .res_o  (res)
  );

  // Sequencer, result register and per-entry valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
      req_q      <= '0;
      addr_q     <= '0;
      ptr_q      <= UNIT_W'(NUM_UNITS - 1);
      st_vld_q   <= '0;
      ct_vld_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (out_o.ready) begin
            out_vld_q <= 1'b0;
          end
          if (accept) begin
            req_q   <= in_i.data;
            addr_q  <= raddr;
            state_q <= S_EXEC;
            if (in_i.data.func == FN_TICK) begin
              ptr_q <= ptr_d;
            end
          end
        end
        S_EXEC: begin
          out_vld_q  <= 1'b1;
          out_data_q <= res;
          state_q    <= S_IDLE;
          if (upd.st_we) begin
            st_vld_q[addr_q] <= 1'b1;
          end
          if (upd.ct_we) begin
            ct_vld_q[addr_q] <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_data_q;

`ifndef NO_ASSERTIONS
  // An accepted word is always worked on in the following cycle.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC))
    else $error("accepted word did not enter execution");

  // A result appears only after an execution cycle.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_EXEC))
    else $error("result raised without execution");

  // A pending result is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> $past(!out_vld_q || out_o.ready))
    else $error("result register overwritten");

  // The poll pointer stays within the unit range.
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ptr_q) < NUM_UNITS)
    else $error("poll pointer out of range");

  // An interrupt always names the polled unit, and only a clean result sends.
  a_irq_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_data_q.irq_valid) |->
      (out_data_q.irq_unit == out_data_q.polled_unit) &&
      (out_data_q.result_code == RC_OK))
    else $error("interrupt unit mismatch");
`endif

endmodule
